FILE: rtl/shuffled_channel_hop_sequencer_core_macros.svh
// -----------------------------------------------------------------------------
// shuffled_channel_hop_sequencer_core_macros.svh
// Assertion macros for the hop sequencer; empty when synthesizing.
// -----------------------------------------------------------------------------
`ifndef SHUFFLED_CHANNEL_HOP_SEQUENCER_CORE_MACROS_SVH
`define SHUFFLED_CHANNEL_HOP_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SCHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("schs assertion failed");
// Next-cycle implication.
`define SCHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("schs assertion failed");
`else
`define SCHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SCHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/schs_pkg.sv
// -----------------------------------------------------------------------------
// schs_pkg
// Shared types and constants of the shuffled channel hop sequencer.
// -----------------------------------------------------------------------------
package schs_pkg;

    localparam logic [31:0] RNG_RESEED = 32'hA5A5_5A5A;
    localparam int RNG_SH_A = 13;
    localparam int RNG_SH_B = 17;
    localparam int RNG_SH_C = 5;
    localparam int DIV_STEPS = 32;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_HOP     = 2'd2;

    localparam logic [1:0] CFG_LIST_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_SHUFFLE_ENABLE = 2'd1;
    localparam logic [1:0] CFG_RNG_SEED       = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OUT,
        S_EMIT,
        S_CP_RD,
        S_CP_WR,
        S_GEN,
        S_DIV,
        S_SW_RDI,
        S_SW_RDJ,
        S_SW_WRI,
        S_SW_WRJ
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load_wr;
        logic take_restart;
        logic take_hop;
        logic rd_out;
        logic emit;
        logic cp_start;
        logic cp_rd;
        logic cp_wr;
        logic sh_init;
        logic gen;
        logic div_step;
        logic sw_rdi;
        logic sw_rdj;
        logic sw_wri;
        logic sw_wrj;
    } t_cmd;

    typedef struct packed {
        logic op_load;
        logic op_restart;
        logic op_hop;
        logic shuffle;
        logic wrapped;
        logic out_free;
        logic cp_last;
        logic n_single;
        logic div_done;
        logic i_last;
    } t_sts;

endpackage

FILE: rtl/schs_in_if.sv
// -----------------------------------------------------------------------------
// schs_in_if
// Input channel: one command beat per handshake.
// -----------------------------------------------------------------------------
interface schs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [6:0] entry_index;
    logic [6:0] entry_value;

    modport source (output valid, operation, entry_index, entry_value, input ready);
    modport sink (input valid, operation, entry_index, entry_value, output ready);
endinterface

FILE: rtl/schs_out_if.sv
// -----------------------------------------------------------------------------
// schs_out_if
// Result channel: one channel beat per handshake.
// -----------------------------------------------------------------------------
interface schs_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] channel;
    logic       pass_wrapped;

    modport source (output valid, channel, pass_wrapped, input ready);
    modport sink (input valid, channel, pass_wrapped, output ready);
endinterface

FILE: rtl/schs_ram.sv
// -----------------------------------------------------------------------------
// schs_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module schs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/schs_ctrl.sv
// -----------------------------------------------------------------------------
// schs_ctrl
// Sequencer state machine: item dispatch, result emit and the shuffle walk.
// -----------------------------------------------------------------------------
module schs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  schs_pkg::t_sts i_sts,
    output schs_pkg::t_cmd o_cmd
);
    import schs_pkg::*;

    t_state r_state, n_state;
    logic   r_restart, n_restart;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_restart <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_restart <= n_restart;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_restart = r_restart;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_sts.op_restart) begin
                    n_restart = 1'b1;
                    n_state   = i_sts.shuffle ? S_CP_RD : S_RD_OUT;
                end else if (w_accept && i_sts.op_hop) begin
                    n_restart = 1'b0;
                    n_state   = S_RD_OUT;
                end
            end
            S_RD_OUT: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    if (!r_restart && i_sts.wrapped && i_sts.shuffle) begin
                        n_state = S_CP_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CP_RD: n_state = S_CP_WR;
            S_CP_WR: begin
                if (!i_sts.cp_last) begin
                    n_state = S_CP_RD;
                end else if (!i_sts.n_single) begin
                    n_state = S_GEN;
                end else begin
                    n_state = r_restart ? S_RD_OUT : S_IDLE;
                end
            end
            S_GEN: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_SW_RDI;
                end
            end
            S_SW_RDI: n_state = S_SW_RDJ;
            S_SW_RDJ: n_state = S_SW_WRI;
            S_SW_WRI: n_state = S_SW_WRJ;
            S_SW_WRJ: begin
                if (!i_sts.i_last) begin
                    n_state = S_GEN;
                end else begin
                    n_state = r_restart ? S_RD_OUT : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready     = 1'b1;
                o_cmd.load_wr      = w_accept && i_sts.op_load;
                o_cmd.take_restart = w_accept && i_sts.op_restart;
                o_cmd.take_hop     = w_accept && i_sts.op_hop;
                o_cmd.cp_start     = w_accept && i_sts.op_restart && i_sts.shuffle;
            end
            S_RD_OUT: o_cmd.rd_out = 1'b1;
            S_EMIT: begin
                o_cmd.emit     = i_sts.out_free;
                o_cmd.cp_start = i_sts.out_free;
            end
            S_CP_RD: o_cmd.cp_rd = 1'b1;
            S_CP_WR: begin
                o_cmd.cp_wr   = 1'b1;
                o_cmd.sh_init = i_sts.cp_last;
            end
            S_GEN:    o_cmd.gen      = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_SW_RDI: o_cmd.sw_rdi   = 1'b1;
            S_SW_RDJ: o_cmd.sw_rdj   = 1'b1;
            S_SW_WRI: o_cmd.sw_wri   = 1'b1;
            S_SW_WRJ: o_cmd.sw_wrj   = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

FILE: rtl/schs_dp.sv
// -----------------------------------------------------------------------------
// schs_dp
// Datapath: config registers, list memories, position, generator,
// serial remainder unit and result register.
// -----------------------------------------------------------------------------
module schs_dp #(
    parameter int LIST_DEPTH = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    input  logic [1:0]     i_operation,
    input  logic [6:0]     i_entry_index,
    input  logic [6:0]     i_entry_value,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [6:0]     o_channel,
    output logic           o_pass_wrapped,
    input  schs_pkg::t_cmd i_cmd,
    output schs_pkg::t_sts o_sts
);
    import schs_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int NW = $clog2(LIST_DEPTH + 1);

    logic [7:0]    r_len;
    logic          r_shuf_en;
    logic [31:0]   r_seed;
    logic [31:0]   r_rng;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_rd_pos;
    logic          r_wrap;
    logic [NW-1:0] r_k;
    logic [AW-1:0] r_i;
    logic [31:0]   r_dvd;
    logic [NW-1:0] r_dvs;
    logic [NW-1:0] r_rem;
    logic [4:0]    r_cnt;
    logic [6:0]    r_ti;
    logic          r_out_valid;
    logic [6:0]    r_chan;
    logic          r_out_wrap;

    logic [NW-1:0] w_n;
    logic [NW-1:0] w_pos;
    logic [NW-1:0] w_pos1;
    logic [31:0]   w_s0, w_s1, w_s2, w_s3;
    logic [NW:0]   w_sh;
    logic [AW-1:0] w_j;
    logic          w_idx_ok;
    logic [6:0]    w_hop_rd, w_shuf_rd;
    logic          w_hop_re, w_shuf_re, w_shuf_we;
    logic [AW-1:0] w_hop_raddr, w_shuf_raddr, w_shuf_waddr;
    logic [6:0]    w_shuf_wdata;

    // effective length, saturated into 1..LIST_DEPTH
    always_comb begin
        if (r_len == 8'd0) begin
            w_n = NW'(1);
        end else if (32'(r_len) > LIST_DEPTH) begin
            w_n = NW'(LIST_DEPTH);
        end else begin
            w_n = NW'(r_len);
        end
    end

    assign w_pos    = (NW'(r_pos) >= w_n) ? '0 : NW'(r_pos);
    assign w_pos1   = w_pos + NW'(1);
    assign w_idx_ok = 32'(i_entry_index) < LIST_DEPTH;
    assign w_j      = r_rem[AW-1:0];

    // xorshift32 with reseed of a zero state
    assign w_s0 = (r_rng == '0) ? (RNG_RESEED ^ r_seed) : r_rng;
    assign w_s1 = w_s0 ^ (w_s0 << RNG_SH_A);
    assign w_s2 = w_s1 ^ (w_s1 >> RNG_SH_B);
    assign w_s3 = w_s2 ^ (w_s2 << RNG_SH_C);

    // one restoring remainder step per cycle
    assign w_sh = {r_rem, r_dvd[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= 8'd1;
            r_shuf_en   <= 1'b0;
            r_seed      <= '0;
            r_rng       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LIST_LENGTH:    r_len     <= i_cfg_data[7:0];
                    CFG_SHUFFLE_ENABLE: r_shuf_en <= i_cfg_data[0];
                    CFG_RNG_SEED:       r_seed    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take_restart) begin
                r_pos <= (w_n > NW'(1)) ? AW'(1) : '0;
            end else if (i_cmd.take_hop) begin
                r_pos <= (w_pos1 >= w_n) ? '0 : w_pos1[AW-1:0];
            end
            if (i_cmd.gen) begin
                r_rng <= w_s3;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_restart) begin
            r_rd_pos <= '0;
            r_wrap   <= 1'b0;
        end else if (i_cmd.take_hop) begin
            r_rd_pos <= w_pos[AW-1:0];
            r_wrap   <= (w_pos1 >= w_n);
        end
        if (i_cmd.cp_start) begin
            r_k <= '0;
        end else if (i_cmd.cp_wr) begin
            r_k <= r_k + NW'(1);
        end
        if (i_cmd.sh_init) begin
            r_i <= AW'(w_n - NW'(1));
        end else if (i_cmd.sw_wrj) begin
            r_i <= r_i - AW'(1);
        end
        if (i_cmd.gen) begin
            r_dvd <= w_s3;
            r_dvs <= NW'(r_i) + NW'(1);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
            if (w_sh >= {1'b0, r_dvs}) begin
                r_rem <= NW'(w_sh - {1'b0, r_dvs});
            end else begin
                r_rem <= w_sh[NW-1:0];
            end
        end
        if (i_cmd.sw_rdj) begin
            r_ti <= w_shuf_rd;
        end
        if (i_cmd.emit) begin
            r_chan     <= r_shuf_en ? w_shuf_rd : w_hop_rd;
            r_out_wrap <= r_wrap;
        end
    end

    // memory port steering
    assign w_hop_re    = i_cmd.cp_rd || i_cmd.rd_out;
    assign w_hop_raddr = i_cmd.cp_rd ? r_k[AW-1:0] : r_rd_pos;

    assign w_shuf_re    = i_cmd.rd_out || i_cmd.sw_rdi || i_cmd.sw_rdj;
    assign w_shuf_raddr = i_cmd.sw_rdi ? r_i : (i_cmd.sw_rdj ? w_j : r_rd_pos);
    assign w_shuf_we    = i_cmd.cp_wr || i_cmd.sw_wri || i_cmd.sw_wrj;
    assign w_shuf_waddr = i_cmd.cp_wr ? r_k[AW-1:0] : (i_cmd.sw_wri ? r_i : w_j);
    assign w_shuf_wdata = i_cmd.cp_wr ? w_hop_rd : (i_cmd.sw_wri ? w_shuf_rd : r_ti);

    schs_ram #(.WIDTH(7), .DEPTH(LIST_DEPTH)) u_hop_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && w_idx_ok),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_re    (w_hop_re),
        .i_raddr (w_hop_raddr),
        .o_rdata (w_hop_rd)
    );

    schs_ram #(.WIDTH(7), .DEPTH(LIST_DEPTH)) u_shuf_ram (
        .i_clk   (i_clk),
        .i_we    (w_shuf_we),
        .i_waddr (w_shuf_waddr),
        .i_wdata (w_shuf_wdata),
        .i_re    (w_shuf_re),
        .i_raddr (w_shuf_raddr),
        .o_rdata (w_shuf_rd)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.op_load    = (i_operation == OP_LOAD);
        o_sts.op_restart = (i_operation == OP_RESTART);
        o_sts.op_hop     = (i_operation == OP_HOP);
        o_sts.shuffle    = r_shuf_en;
        o_sts.wrapped    = r_wrap;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.cp_last    = (r_k + NW'(1)) == w_n;
        o_sts.n_single   = (w_n == NW'(1));
        o_sts.div_done   = (r_cnt == 5'(DIV_STEPS - 1));
        o_sts.i_last     = (r_i == AW'(1));
    end

    assign o_out_valid    = r_out_valid;
    assign o_channel      = r_chan;
    assign o_pass_wrapped = r_out_wrap;
endmodule

FILE: rtl/shuffled_channel_hop_sequencer_core.sv
// -----------------------------------------------------------------------------
// shuffled_channel_hop_sequencer_core
// Channel hop-list sequencer with optional Fisher-Yates reshuffle per pass.
// -----------------------------------------------------------------------------
// Load beats write one list entry. Restart and hop beats each give one
// channel beat; without a reshuffle an item reads the list memory and then
// loads the result register once the output side is free. A reshuffle, done
// on restart with shuffle on and at the end of every pass, copies the list
// entry by entry and then draws n-1 random swaps; each draw is one xorshift32
// step, a bit-serial reduction in the remainder unit and a swap (read i, read
// j, write i, write j) through the shuffle memory, which has one read and one
// write port. The result register frees the output side: a channel beat
// waits there while the reshuffle runs. Input beats are taken only while the
// sequencer is idle. Configuration (index 0 list length, 1 shuffle enable, 2
// seed) is to be written by the user only when idle; the block does not
// enforce this. List entries read before being written return arbitrary values.
// -----------------------------------------------------------------------------
`include "shuffled_channel_hop_sequencer_core_macros.svh"

module shuffled_channel_hop_sequencer_core #(
    parameter int LIST_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    schs_in_if.sink     i_in,
    schs_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import schs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_shuf_busy;

    // hold the input off while a beat is being worked
    assign i_in.ready = w_cmd.in_ready;

    // copy writes, draws, remainder steps and swap writes of the shuffle walk
    assign w_shuf_busy = w_cmd.gen || w_cmd.div_step || w_cmd.cp_wr ||
                         w_cmd.sw_wri || w_cmd.sw_wrj;

    schs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    schs_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_in.operation),
        .i_entry_index  (i_in.entry_index),
        .i_entry_value  (i_in.entry_value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_channel      (o_out.channel),
        .o_pass_wrapped (o_out.pass_wrapped),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts)
    );

    // never overwrite a pending result beat
    `SCHS_ASSERT_IMPLY(a_emit_free, i_clk, i_rst_n, w_cmd.emit, w_sts.out_free)
    // no shuffle work while input beats are taken
    `SCHS_ASSERT_IMPLY(a_idle_quiet, i_clk, i_rst_n, i_in.ready, !w_shuf_busy)
    // a draw starts the remainder unit right away
    `SCHS_ASSERT_NEXT(a_gen_div, i_clk, i_rst_n, w_cmd.gen, w_cmd.div_step)
endmodule

FILE: test/shuffled_channel_hop_sequencer_core_checker.sv
// -----------------------------------------------------------------------------
// shuffled_channel_hop_sequencer_core_checker
// Watches the command and channel beats, mirrors the register writes, keeps
// its own hop list, shuffle order and generator state, and compares each
// channel beat with the oldest predicted one.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module shuffled_channel_hop_sequencer_core_checker #(
    parameter int LIST_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    schs_in_if          i_cmd,
    schs_out_if         i_hop,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_failures,
    output int          o_pending,
    output int          o_channels_seen,
    output int          o_wraps_seen
);
    import schs_pkg::*;

    typedef struct packed {
        logic [6:0] channel;
        logic       pass_wrapped;
    } t_hop_beat;

    logic [6:0]  plan_list [LIST_DEPTH];
    logic [6:0]  plan_order[LIST_DEPTH];
    logic [31:0] gen_state;
    int          plan_pos;
    logic [7:0]  cfg_length;
    logic        cfg_shuffle;
    logic [31:0] cfg_seed;
    t_hop_beat   hops_due[$];

    function automatic int active_length();
        if (cfg_length == 8'd0) return 1;
        if (int'(cfg_length) > LIST_DEPTH) return LIST_DEPTH;
        return int'(cfg_length);
    endfunction

    function automatic logic [31:0] draw_random();
        logic [31:0] s;
        s = (gen_state == 32'd0) ? (RNG_RESEED ^ cfg_seed) : gen_state;
        s = s ^ (s << RNG_SH_A);
        s = s ^ (s >> RNG_SH_B);
        s = s ^ (s << RNG_SH_C);
        gen_state = s;
        return s;
    endfunction

    function automatic void deal_order(int n);
        int         j;
        logic [6:0] t;
        for (int i = 0; i < n; i++) plan_order[i] = plan_list[i];
        for (int i = n - 1; i > 0; i--) begin
            j = int'(draw_random() % (i + 1));
            t = plan_order[i];
            plan_order[i] = plan_order[j];
            plan_order[j] = t;
        end
    endfunction

    function automatic logic [6:0] pick_channel(int pos);
        return cfg_shuffle ? plan_order[pos] : plan_list[pos];
    endfunction

    always @(posedge i_clk) begin
        int        n;
        int        pos;
        t_hop_beat want;
        t_hop_beat got;
        if (!i_rst_n) begin
            gen_state = '0;
            plan_pos = 0;
            cfg_length = 8'd1;
            cfg_shuffle = 1'b0;
            cfg_seed = '0;
            hops_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LIST_LENGTH:    cfg_length = i_cfg_data[7:0];
                    CFG_SHUFFLE_ENABLE: cfg_shuffle = i_cfg_data[0];
                    CFG_RNG_SEED:       cfg_seed = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                n = active_length();
                case (i_cmd.operation)
                    OP_LOAD: plan_list[i_cmd.entry_index] = i_cmd.entry_value;
                    OP_RESTART: begin
                        if (cfg_shuffle) deal_order(n);
                        want.channel = pick_channel(0);
                        want.pass_wrapped = 1'b0;
                        hops_due.push_back(want);
                        plan_pos = (n > 1) ? 1 : 0;
                    end
                    OP_HOP: begin
                        pos = (plan_pos >= n) ? 0 : plan_pos;
                        want.channel = pick_channel(pos);
                        want.pass_wrapped = 1'b0;
                        pos++;
                        if (pos >= n) begin
                            pos = 0;
                            want.pass_wrapped = 1'b1;
                            if (cfg_shuffle) deal_order(n);
                        end
                        plan_pos = pos;
                        hops_due.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (i_hop.valid && i_hop.ready) begin
                got.channel = i_hop.channel;
                got.pass_wrapped = i_hop.pass_wrapped;
                o_channels_seen++;
                if (got.pass_wrapped) o_wraps_seen++;
                if (hops_due.size() == 0) begin
                    $error("channel beat %0d with nothing predicted", got.channel);
                    o_failures++;
                end else begin
                    want = hops_due.pop_front();
                    if (got.channel !== want.channel) begin
                        $error("channel: expected %0d, actual %0d", want.channel,
                               got.channel);
                        o_failures++;
                    end
                    if (got.pass_wrapped !== want.pass_wrapped) begin
                        $error("pass_wrapped: expected %0d, actual %0d",
                               want.pass_wrapped, got.pass_wrapped);
                        o_failures++;
                    end
                end
            end
        end
        o_pending = hops_due.size();
    end

    initial begin
        o_failures = 0;
        o_pending = 0;
        o_channels_seen = 0;
        o_wraps_seen = 0;
    end

endmodule

FILE: test/shuffled_channel_hop_sequencer_core_test.sv
// -----------------------------------------------------------------------------
// shuffled_channel_hop_sequencer_core_test
// Drives the hop sequencer through a series of register settings: plain and
// shuffled order, a generator that never leaves zero, zero and oversized list
// lengths, stale positions and a full 128-entry list, with random loads,
// restarts, hops and unused commands under random back-pressure.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module shuffled_channel_hop_sequencer_core_test;
    import schs_pkg::*;

    localparam int         DEPTH      = 128;
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         ITEM_GOAL  = 950;
    localparam int         HOLD_LEN   = 400;
    localparam int         IDLE_LIMIT = 30000;
    localparam int         SETTLE     = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int failures;
    int pending;
    int channels_seen;
    int wraps_seen;
    int cmds_sent;
    int quiet_cycles;
    int settings_run;
    bit hold_req;
    bit calm_mode;

    schs_in_if  cmd_ch ();
    schs_out_if hop_ch ();

    shuffled_channel_hop_sequencer_core #(.LIST_DEPTH(DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_ch),
        .o_out       (hop_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    shuffled_channel_hop_sequencer_core_checker #(.LIST_DEPTH(DEPTH)) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_ch),
        .i_hop           (hop_ch),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_channels_seen (channels_seen),
        .o_wraps_seen    (wraps_seen)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one command beat and hold it until taken; then maybe idle.
    // Valid stays high across back-to-back beats so it is never dropped and
    // raised in the same step.
    task automatic send_cmd(logic [1:0] op, logic [6:0] idx, logic [6:0] val);
        int gap;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= op;
        cmd_ch.entry_index <= idx;
        cmd_ch.entry_value <= val;
        do @(posedge i_clk); while (!cmd_ch.ready);
        cmds_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every predicted beat is out and the sequencer
    // is back to idle (a trailing reshuffle can run long), then settle.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !cmd_ch.ready) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all three registers in consecutive cycles, sequencer idle.
    task automatic program_regs(logic [7:0] len, logic shuf, logic [31:0] seed);
        cfg_we <= 1'b1;
        cfg_index <= CFG_LIST_LENGTH;
        cfg_data <= {24'd0, len};
        @(posedge i_clk);
        cfg_index <= CFG_SHUFFLE_ENABLE;
        cfg_data <= {31'd0, shuf};
        @(posedge i_clk);
        cfg_index <= CFG_RNG_SEED;
        cfg_data <= seed;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // One random beat: mostly hops, some restarts and reloads, rare unused
    // commands. Every entry is loaded up front, so reloads never leave holes.
    task automatic send_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            send_cmd(OP_LOAD, 7'($urandom_range(0, DEPTH - 1)), 7'($urandom));
        else if (r < 25)
            send_cmd(OP_RESTART, 7'($urandom), 7'($urandom));
        else if (r < 95)
            send_cmd(OP_HOP, 7'($urandom), 7'($urandom));
        else
            send_cmd(OP_UNUSED, 7'($urandom), 7'($urandom));
    endtask

    // New setting: drain, write registers, restart when the shuffled order
    // has to be rebuilt for the new length, then run a batch of beats.
    task automatic run_setting(logic [7:0] len, logic shuf, logic [31:0] seed,
                               int beats);
        drain();
        program_regs(len, shuf, seed);
        if (shuf) send_cmd(OP_RESTART, 7'd0, 7'd0);
        repeat (beats) send_random();
    endtask

    // Result side: random ready, with a long hold-off on request.
    initial begin
        int gap;
        hop_ch.ready <= 1'b0;
        forever begin
            if (hold_req) begin
                hop_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                hop_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            hop_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Watchdog: abort when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (hop_ch.valid && hop_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        quiet_cycles = 0;
        cmds_sent = 0;
        settings_run = 0;
        hold_req = 1'b0;
        calm_mode = 1'b0;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_LIST_LENGTH;
        cfg_data <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.operation <= OP_LOAD;
        cmd_ch.entry_index <= '0;
        cmd_ch.entry_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole list so no read can hit an unwritten entry; the
        // first and last entries take the extreme channel values.
        calm_mode = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0)
                send_cmd(OP_LOAD, 7'(i), 7'd127);
            else if (i == DEPTH - 1)
                send_cmd(OP_LOAD, 7'(i), 7'd0);
            else
                send_cmd(OP_LOAD, 7'(i), 7'($urandom));
        end
        calm_mode = 1'b0;

        // Directed: registers at reset values, one-entry list.
        send_cmd(OP_RESTART, 7'd0, 7'd0);
        send_cmd(OP_HOP, 7'd0, 7'd0);
        send_cmd(OP_UNUSED, 7'd127, 7'd127);
        send_cmd(OP_HOP, 7'd127, 7'd127);
        send_cmd(OP_LOAD, 7'd127, 7'd127);
        send_cmd(OP_LOAD, 7'd0, 7'd0);
        send_cmd(OP_HOP, 7'd0, 7'd0);

        // Plain order over six entries, then shrink without a restart so the
        // position left behind is past the new end.
        drain();
        program_regs(8'd6, 1'b0, 32'd0);
        send_cmd(OP_RESTART, 7'd0, 7'd0);
        repeat (4) send_cmd(OP_HOP, 7'd0, 7'd0);
        drain();
        program_regs(8'd3, 1'b0, 32'd0);
        repeat (4) send_cmd(OP_HOP, 7'd0, 7'd0);

        // Seed that cancels the reseed constant: generator stuck at zero.
        run_setting(8'd5, 1'b1, RNG_RESEED, 12);
        // Zero length acts as one; oversized lengths saturate to the depth.
        run_setting(8'd0, 1'b1, $urandom, 6);
        run_setting(8'd255, 1'b0, 32'd0, 10);
        run_setting(8'd2, 1'b1, 32'hFFFF_FFFF, 10);
        // Full list, shuffled: long reshuffles, one full pass and a bit.
        drain();
        program_regs(8'd128, 1'b1, $urandom);
        send_cmd(OP_RESTART, 7'd0, 7'd0);
        calm_mode = 1'b1;
        repeat (DEPTH + 2) send_cmd(OP_HOP, 7'd0, 7'd0);
        calm_mode = 1'b0;

        // Random settings, mostly short lists to keep reshuffles cheap.
        while (cmds_sent < ITEM_GOAL) begin
            calm_mode = ($urandom_range(0, 5) == 0);
            drain();
            program_regs($urandom_range(0, 9) == 0 ? 8'($urandom)
                                                   : 8'($urandom_range(1, 12)),
                         1'($urandom), $urandom);
            send_cmd(OP_RESTART, 7'd0, 7'd0);
            repeat (30) send_random();
            // Once, stall the result side while commands keep coming.
            if (settings_run == 12) begin
                hold_req = 1'b1;
                repeat (12) send_random();
            end
        end
        calm_mode = 1'b0;

        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d command beats over %0d register settings;", cmds_sent,
                 settings_run);
        $display("checked %0d channel beats, %0d of them ending a pass.",
                 channels_seen, wraps_seen);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
